// ----- rtl/crme_pkg.sv -----
// ============================================================================
// crme_pkg: shared types and constants of the circle and ring mesh expander
// Holds the command codes, the controller and datapath handshake structures
// and the fixed-point spoke table arithmetic.
// ============================================================================
package crme_pkg;

  localparam int COORD_W = 16;
  localparam int INDEX_W = 16;
  localparam int TOTAL_W = 20;
  localparam int COLOR_W = 32;
  localparam int UNIT_W  = 16;

  localparam logic [TOTAL_W-1:0] INDEX_MAX = {TOTAL_W{1'b1}};
  localparam logic [INDEX_W-1:0] VERTEX_MAX = {INDEX_W{1'b1}};

  localparam logic [63:0] PI_Q28  = 64'd843314857;
  localparam logic [63:0] ONE_Q28 = 64'd268435456;

  typedef enum logic [2:0] {
    OP_CLEAR  = 3'd0,
    OP_VERTEX = 3'd1,
    OP_TRI    = 3'd2,
    OP_CIRCLE = 3'd3,
    OP_RING   = 3'd4
  } op_e_t;

  // What the datapath places in the output register.
  typedef enum logic [2:0] {
    KIND_CLEAR,
    KIND_VERTEX,
    KIND_TRI,
    KIND_CENTRE,
    KIND_RIM,
    KIND_OUTER,
    KIND_INNER
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic  load;
    logic  mul;
    logic  use_outer;
    logic  emit;
    kind_t kind;
    logic  last;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

  // One Taylor term divided by its factorial step; the divisors are fixed.
  function automatic logic [63:0] term_div(input logic [63:0] prod, input int k,
                                           input logic want_sin);
    logic [63:0] res;
    res = prod;
    if (want_sin) begin
      case (k)
        1: res = prod / 64'd6;
        2: res = prod / 64'd20;
        3: res = prod / 64'd42;
        4: res = prod / 64'd72;
        default: res = prod / 64'd110;
      endcase
    end else begin
      case (k)
        1: res = prod / 64'd2;
        2: res = prod / 64'd12;
        3: res = prod / 64'd30;
        4: res = prod / 64'd56;
        default: res = prod / 64'd90;
      endcase
    end
    return res;
  endfunction

  // Sine or cosine in Q1.14 of a quarter-turn fraction r, clamped to [0, 1].
  function automatic logic signed [UNIT_W-1:0] taylor_q14(input logic [13:0] r,
                                                         input logic want_sin);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        rnd;
    x    = ({50'd0, r} * PI_Q28 + 64'd16384) >> 15;
    x2   = (x * x + (64'd1 << 27)) >> 28;
    term = want_sin ? x : ONE_Q28;
    sum  = signed'(term);
    for (int k = 1; k <= 5; k++) begin
      term = term_div((term * x2) >> 28, k, want_sin);
      if (k % 2 == 1) sum = sum - signed'(term);
      else            sum = sum + signed'(term);
    end
    if (sum < 0) sum = 0;
    if (sum > signed'(ONE_Q28)) sum = signed'(ONE_Q28);
    rnd = (unsigned'(sum) + 64'd8192) >> 14;
    return signed'(rnd[UNIT_W-1:0]);
  endfunction

endpackage

// ----- rtl/crme_if.sv -----
// ============================================================================
// crme_in_if / crme_out_if: request channels of the mesh expander
// Valid and ready handshake; a request moves at a clock edge with both high.
// ============================================================================
interface crme_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         op;
  logic signed [15:0] center_x;
  logic signed [15:0] center_y;
  logic [15:0]        radius;
  logic [15:0]        ring_outer;
  logic [31:0]        color;
  logic [15:0]        tri_first;
  logic [15:0]        tri_second;
  logic [15:0]        tri_third;

  modport source (output valid, op, center_x, center_y, radius, ring_outer, color,
                  tri_first, tri_second, tri_third, input ready);
  modport sink (input valid, op, center_x, center_y, radius, ring_outer, color,
                tri_first, tri_second, tri_third, output ready);
endinterface

interface crme_out_if;
  logic               valid;
  logic               ready;
  logic               has_vertex;
  logic signed [15:0] vertex_x;
  logic signed [15:0] vertex_y;
  logic [31:0]        vertex_color;
  logic               has_triangle;
  logic [15:0]        corner_a;
  logic [15:0]        corner_b;
  logic [15:0]        corner_c;
  logic [19:0]        indices_total;
  logic               overflow;
  logic               last;

  modport source (output valid, has_vertex, vertex_x, vertex_y, vertex_color, has_triangle,
                  corner_a, corner_b, corner_c, indices_total, overflow, last,
                  input ready);
  modport sink (input valid, has_vertex, vertex_x, vertex_y, vertex_color, has_triangle,
                corner_a, corner_b, corner_c, indices_total, overflow, last,
                output ready);
endinterface

// ----- rtl/crme_ctrl.sv -----
// ============================================================================
// crme_ctrl: command sequencer of the mesh expander
// Walks each request through its results, one spoke multiply and one emit
// at a time.
// ============================================================================
module crme_ctrl #(
  parameter int SPOKES = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [2:0]                in_op,
  output logic                      in_ready,
  input  crme_pkg::status_t         status,
  output crme_pkg::cmd_t            cmd,
  output logic [$clog2(SPOKES)-1:0] spoke
);
  import crme_pkg::*;

  localparam int SW = $clog2(SPOKES);
  localparam logic [SW-1:0] FINAL_SPOKE = SW'(SPOKES - 1);

  state_t        state_r, state_nxt;
  kind_t         kind_r, kind_nxt;
  logic [SW-1:0] spoke_r, spoke_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      kind_r  <= KIND_CLEAR;
      spoke_r <= '0;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
      spoke_r <= spoke_nxt;
    end
  end

  assign spoke = spoke_r;

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    spoke_nxt     = spoke_r;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.kind      = kind_r;
    cmd.use_outer = (kind_r == KIND_OUTER);
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          spoke_nxt = '0;
          unique case (in_op)
            OP_CLEAR: begin
              kind_nxt  = KIND_CLEAR;
              state_nxt = ST_EMIT;
            end
            OP_VERTEX: begin
              kind_nxt  = KIND_VERTEX;
              state_nxt = ST_EMIT;
            end
            OP_TRI: begin
              kind_nxt  = KIND_TRI;
              state_nxt = ST_EMIT;
            end
            OP_CIRCLE: begin
              kind_nxt  = KIND_CENTRE;
              state_nxt = ST_EMIT;
            end
            OP_RING: begin
              kind_nxt  = KIND_OUTER;
              state_nxt = ST_MUL;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        unique case (kind_r)
          KIND_CENTRE, KIND_OUTER: cmd.last = 1'b0;
          KIND_RIM, KIND_INNER:    cmd.last = (spoke_r == FINAL_SPOKE);
          default:                 cmd.last = 1'b1;
        endcase
        if (status.out_free) begin
          cmd.emit = 1'b1;
          unique case (kind_r)
            KIND_CENTRE: begin
              kind_nxt  = KIND_RIM;
              state_nxt = ST_MUL;
            end
            KIND_RIM: begin
              if (spoke_r == FINAL_SPOKE) begin
                state_nxt = ST_IDLE;
              end else begin
                spoke_nxt = spoke_r + 1'b1;
                state_nxt = ST_MUL;
              end
            end
            KIND_OUTER: begin
              kind_nxt  = KIND_INNER;
              state_nxt = ST_MUL;
            end
            KIND_INNER: begin
              if (spoke_r == FINAL_SPOKE) begin
                state_nxt = ST_IDLE;
              end else begin
                spoke_nxt = spoke_r + 1'b1;
                kind_nxt  = KIND_OUTER;
                state_nxt = ST_MUL;
              end
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ----- rtl/crme_dp.sv -----
// ============================================================================
// crme_dp: datapath of the mesh expander
// Holds the request, the running counts, the spoke table, the spoke
// multipliers and the output register.
// ============================================================================
module crme_dp #(
  parameter int SPOKES = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic signed [15:0]        in_center_x,
  input  logic signed [15:0]        in_center_y,
  input  logic [15:0]               in_radius,
  input  logic [15:0]               in_ring_outer,
  input  logic [31:0]               in_color,
  input  logic [15:0]               in_tri_first,
  input  logic [15:0]               in_tri_second,
  input  logic [15:0]               in_tri_third,
  input  crme_pkg::cmd_t            cmd,
  input  logic [$clog2(SPOKES)-1:0] spoke,
  output crme_pkg::status_t         status,
  crme_out_if.source                out_if
);
  import crme_pkg::*;

  localparam int SW    = $clog2(SPOKES);
  localparam int ABS_W = UNIT_W - 1;
  localparam int MAG_W = (UNIT_W - 1) + COORD_W;
  localparam int OFF_W = MAG_W - 14;
  localparam int SUM_W = COORD_W + 2;
  localparam logic [SW-1:0] FINAL_SPOKE = SW'(SPOKES - 1);

  // Spoke unit vector, sine for x and cosine for y.
  function automatic logic signed [UNIT_W-1:0] spoke_unit(input int i, input logic want_x);
    logic [63:0]               ph;
    logic [1:0]                q;
    logic [13:0]               r;
    logic signed [UNIT_W-1:0]  s;
    logic signed [UNIT_W-1:0]  c;
    logic signed [UNIT_W-1:0]  res;
    ph  = (64'(i) * 64'd65536 + 64'(SPOKES / 2)) / SPOKES;
    q   = ph[15:14];
    r   = ph[13:0];
    s   = taylor_q14(r, 1'b1);
    c   = taylor_q14(r, 1'b0);
    case (q)
      2'd0:    res = want_x ? s : c;
      2'd1:    res = want_x ? c : -s;
      2'd2:    res = want_x ? -s : -c;
      default: res = want_x ? -c : s;
    endcase
    return res;
  endfunction

  logic signed [UNIT_W-1:0] sin_tab [SPOKES];
  logic signed [UNIT_W-1:0] cos_tab [SPOKES];

  for (genvar g = 0; g < SPOKES; g++) begin : g_rom
    localparam logic signed [UNIT_W-1:0] SIN_V = spoke_unit(g, 1'b1);
    localparam logic signed [UNIT_W-1:0] COS_V = spoke_unit(g, 1'b0);
    assign sin_tab[g] = SIN_V;
    assign cos_tab[g] = COS_V;
  end

  // Request registers.
  logic signed [COORD_W-1:0] cx_r, cy_r;
  logic [COORD_W-1:0]        rin_r, rout_r;
  logic [COLOR_W-1:0]        col_r;
  logic [INDEX_W-1:0]        tri_a_r, tri_b_r, tri_c_r;
  logic [INDEX_W-1:0]        base_r;

  // Running counts.
  logic [INDEX_W-1:0] vtot_r, vtot_nxt;
  logic [TOTAL_W-1:0] itot_r, itot_nxt;
  logic               ovf_r, ovf_nxt;

  // Product stage.
  logic [MAG_W-1:0] mag_x_r, mag_y_r;
  logic             neg_x_r, neg_y_r;

  // Output register.
  logic               out_valid_r, out_valid_nxt;
  logic               hv_r, ht_r, last_r, ovf_out_r;
  logic [COORD_W-1:0] vx_r, vy_r;
  logic [COLOR_W-1:0] vcol_r;
  logic [INDEX_W-1:0] ca_r, cb_r, cc_r;
  logic [TOTAL_W-1:0] itot_out_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cx_r    <= in_center_x;
      cy_r    <= in_center_y;
      rin_r   <= in_radius;
      rout_r  <= in_ring_outer;
      col_r   <= in_color;
      tri_a_r <= in_tri_first;
      tri_b_r <= in_tri_second;
      tri_c_r <= in_tri_third;
      base_r  <= vtot_r;
    end
  end

  // Multiply stage: magnitude of the unit times the radius.
  logic [COORD_W-1:0]       rad;
  logic signed [UNIT_W-1:0] us, uc;
  logic [UNIT_W-2:0]        abs_s, abs_c;

  always_comb begin
    rad   = cmd.use_outer ? rout_r : rin_r;
    us    = sin_tab[spoke];
    uc    = cos_tab[spoke];
    abs_s = us[UNIT_W-1] ? ABS_W'(-us) : us[UNIT_W-2:0];
    abs_c = uc[UNIT_W-1] ? ABS_W'(-uc) : uc[UNIT_W-2:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      mag_x_r <= MAG_W'(abs_s) * MAG_W'(rad);
      mag_y_r <= MAG_W'(abs_c) * MAG_W'(rad);
      neg_x_r <= us[UNIT_W-1];
      neg_y_r <= uc[UNIT_W-1];
    end
  end

  // Round half away from zero, offset the centre and saturate.
  function automatic logic [COORD_W-1:0] place(input logic signed [COORD_W-1:0] centre,
                                               input logic [MAG_W-1:0] mag,
                                               input logic neg);
    logic [MAG_W-1:0]        rnd;
    logic signed [SUM_W-1:0] off;
    logic signed [SUM_W-1:0] v;
    logic [COORD_W-1:0]      res;
    rnd = mag + MAG_W'(8192);
    off = signed'({1'b0, rnd[MAG_W-1:14]});
    v   = neg ? SUM_W'(centre) - off : SUM_W'(centre) + off;
    if (v > SUM_W'(32767))       res = 16'h7FFF;
    else if (v < -SUM_W'(32768)) res = 16'h8000;
    else                         res = v[COORD_W-1:0];
    return res;
  endfunction

  logic [SW-1:0]      prev;
  logic [INDEX_W-1:0] k1, p1, k2, p2;
  logic               hv, ht;
  logic [COORD_W-1:0] vx, vy;
  logic [COLOR_W-1:0] vcol;
  logic [INDEX_W-1:0] ca, cb, cc;

  always_comb begin
    prev = (spoke == '0) ? FINAL_SPOKE : spoke - 1'b1;
    k1   = INDEX_W'(spoke);
    p1   = INDEX_W'(prev);
    k2   = INDEX_W'({spoke, 1'b0});
    p2   = INDEX_W'({prev, 1'b0});
    hv   = 1'b0;
    ht   = 1'b0;
    vx   = '0;
    vy   = '0;
    vcol = '0;
    ca   = '0;
    cb   = '0;
    cc   = '0;
    case (cmd.kind)
      KIND_VERTEX, KIND_CENTRE: begin
        hv   = 1'b1;
        vx   = cx_r;
        vy   = cy_r;
        vcol = col_r;
      end
      KIND_TRI: begin
        ht = 1'b1;
        ca = tri_a_r;
        cb = tri_b_r;
        cc = tri_c_r;
      end
      KIND_RIM: begin
        hv = 1'b1;
        ht = 1'b1;
        ca = base_r;
        cb = base_r + p1 + 1'b1;
        cc = base_r + k1 + 1'b1;
      end
      KIND_OUTER: begin
        hv = 1'b1;
        ht = 1'b1;
        ca = base_r + p2 + 1'b1;
        cb = base_r + p2;
        cc = base_r + k2;
      end
      KIND_INNER: begin
        hv = 1'b1;
        ht = 1'b1;
        ca = base_r + k2;
        cb = base_r + p2 + 1'b1;
        cc = base_r + k2 + 1'b1;
      end
      default: ;
    endcase
    if (cmd.kind == KIND_RIM || cmd.kind == KIND_OUTER || cmd.kind == KIND_INNER) begin
      vx   = place(cx_r, mag_x_r, neg_x_r);
      vy   = place(cy_r, mag_y_r, neg_y_r);
      vcol = col_r;
    end
  end

  // Counts after this result.
  always_comb begin
    vtot_nxt = vtot_r;
    itot_nxt = itot_r;
    ovf_nxt  = ovf_r;
    if (cmd.emit) begin
      if (cmd.kind == KIND_CLEAR) begin
        vtot_nxt = '0;
        itot_nxt = '0;
        ovf_nxt  = 1'b0;
      end else begin
        if (hv) begin
          vtot_nxt = vtot_r + 1'b1;
          ovf_nxt  = ovf_r | (vtot_r == VERTEX_MAX);
        end
        if (ht) begin
          itot_nxt = (itot_r > INDEX_MAX - TOTAL_W'(3)) ? INDEX_MAX : itot_r + TOTAL_W'(3);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vtot_r <= '0;
      itot_r <= '0;
      ovf_r  <= 1'b0;
    end else begin
      vtot_r <= vtot_nxt;
      itot_r <= itot_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

  assign status.out_free = !out_valid_r || out_if.ready;
  assign out_valid_nxt   = cmd.emit ? 1'b1 : (out_if.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      hv_r       <= hv;
      vx_r       <= vx;
      vy_r       <= vy;
      vcol_r     <= vcol;
      ht_r       <= ht;
      ca_r       <= ca;
      cb_r       <= cb;
      cc_r       <= cc;
      itot_out_r <= itot_nxt;
      ovf_out_r  <= ovf_nxt;
      last_r     <= cmd.last;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.has_vertex    = hv_r;
  assign out_if.vertex_x      = vx_r;
  assign out_if.vertex_y      = vy_r;
  assign out_if.vertex_color  = vcol_r;
  assign out_if.has_triangle  = ht_r;
  assign out_if.corner_a      = ca_r;
  assign out_if.corner_b      = cb_r;
  assign out_if.corner_c      = cc_r;
  assign out_if.indices_total = itot_out_r;
  assign out_if.overflow      = ovf_out_r;
  assign out_if.last          = last_r;

endmodule

// ----- rtl/circle_ring_mesh_expander.sv -----
// ============================================================================
// circle_ring_mesh_expander: drawing commands to mesh vertices and triangles
// Clear, vertex, triangle, filled circle and ring requests become a stream of
// result requests, each carrying a vertex, an index triple or both.
// ============================================================================
// Sequence: a request is taken in the idle step and each result is registered in
// an emit step; a ring result, and every circle result after the centre, follows a
// multiply step. A stalled output holds the emit step, and no new request is taken
// until the last result of the previous one has been emitted.
// Reset (rst_n low, synchronous): the vertex count, index count, overflow flag,
// sequencer and output valid clear; the spoke table is constant logic.
module circle_ring_mesh_expander #(
  parameter int SPOKES = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  crme_in_if.sink    in_if,
  crme_out_if.source out_if
);
  import crme_pkg::*;

  localparam int SW = $clog2(SPOKES);

  // The controller sequences each request; the datapath holds every value.
  cmd_t          cmd;
  status_t       status;
  logic [SW-1:0] spoke;

  crme_ctrl #(
    .SPOKES (SPOKES)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_op    (in_if.op),
    .in_ready (in_if.ready),
    .status   (status),
    .cmd      (cmd),
    .spoke    (spoke)
  );

  // The datapath's output register decouples the result side, so a stalled
  // result only holds the sequencer in its emit step.
  crme_dp #(
    .SPOKES (SPOKES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_center_x     (in_if.center_x),
    .in_center_y     (in_if.center_y),
    .in_radius       (in_if.radius),
    .in_ring_outer   (in_if.ring_outer),
    .in_color        (in_if.color),
    .in_tri_first    (in_if.tri_first),
    .in_tri_second   (in_if.tri_second),
    .in_tri_third    (in_if.tri_third),
    .cmd             (cmd),
    .spoke           (spoke),
    .status          (status),
    .out_if          (out_if)
  );

endmodule
